FILE: rtl/pcie_dllp_decoder_core_defines.svh
// assertion macros for the checker of the dllp decoder
`ifndef PCIE_DLLP_DECODER_CORE_DEFINES_SVH
`define PCIE_DLLP_DECODER_CORE_DEFINES_SVH

// clocked property, off during reset
`define PDLLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a stalled record beat keeps valid and the given field
`define PDLLP_HOLD(lbl, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(rec_valid && rec_stall) |=> (rec_valid && $stable(sig))) else $error(msg);

`endif

FILE: rtl/pdllp_pkg.sv
`default_nettype none

package pdllp_pkg;

	// symbol classes from the logical layer
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	// record status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_CRC_BAD   = 2'd1;
	localparam logic [1:0] STS_TRUNCATED = 2'd2;
	localparam logic [1:0] STS_NO_END    = 2'd3;

	// dllp classes
	localparam logic [1:0] CLS_ACKNAK = 2'd0;
	localparam logic [1:0] CLS_PM     = 2'd1;
	localparam logic [1:0] CLS_VENDOR = 2'd2;
	localparam logic [1:0] CLS_FC     = 2'd3;

	// dllp type codes
	localparam logic [7:0] TYPE_ACK        = 8'h00;
	localparam logic [7:0] TYPE_NAK        = 8'h10;
	localparam logic [7:0] TYPE_PM_L1      = 8'h20;
	localparam logic [7:0] TYPE_PM_L23     = 8'h21;
	localparam logic [7:0] TYPE_PM_AS_L1   = 8'h23;
	localparam logic [7:0] TYPE_PM_REQ_ACK = 8'h24;
	localparam logic [7:0] TYPE_VENDOR     = 8'h30;

	// crc-16, reflected
	localparam logic [15:0] CRC_POLY = 16'hd008;
	localparam logic [15:0] CRC_INIT = 16'hffff;

	// number of dllp bytes, type through second crc byte
	localparam logic [2:0] NBYTES_FULL = 3'd6;

	// one byte through the lsb-first lfsr
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pcie_dllp_decoder_core.sv
`default_nettype none

// DLLP decoder: takes one link symbol per beat (start, data byte, end, other), gathers
// type, three body bytes and two crc bytes, checks the crc-16 over type and body, and
// gives one record per dllp once it completes or aborts after its type byte. A symbol
// beat can be taken every cycle while the record side does not stall; the symbol that
// closes a dllp passes the symbol register, then the record register. The crc is one
// byte of unrolled xor logic per cycle, which sets that rate. A stall on the record
// side holds the symbol register and, through it, the symbol side.
module pcie_dllp_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// symbol channel
	input  wire logic        sym_valid,
	output logic             sym_stall,
	input  wire logic [1:0]  sym_kind,
	input  wire logic [7:0]  sym_byte,
	// record channel
	output logic             rec_valid,
	input  wire logic        rec_stall,
	output logic [1:0]       status,
	output logic [1:0]       dllp_class,
	output logic [7:0]       type_code,
	output logic [3:0]       vc_id,
	output logic [15:0]      seq_field,
	output logic [7:0]       hdr_credits,
	output logic [11:0]      data_credits,
	output logic [23:0]      body_payload,
	output logic [15:0]      crc_received,
	output logic [2:0]       bytes_seen
);
	import pdllp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_B1,
		PH_B2,
		PH_B3,
		PH_C1,
		PH_C2,
		PH_END
	} phase_t;

	phase_t      phase_q, nxt_phase;
	logic [7:0]  type_q, nxt_type;
	logic [23:0] body_q, nxt_body;
	logic [7:0]  crc_hi_q, nxt_crc_hi;
	logic [15:0] crc_q, nxt_crc;
	logic        good_q, nxt_good;

	// symbol register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  byte_s1;

	// record register
	logic        rec_valid_q;
	logic [1:0]  status_q;
	logic [1:0]  class_q;
	logic [7:0]  type_out_q;
	logic [3:0]  vc_q;
	logic [15:0] seq_q;
	logic [7:0]  hdr_q;
	logic [11:0] dat_q;
	logic [23:0] body_out_q;
	logic [15:0] crc_rx_q;
	logic [2:0]  nbytes_q;

	logic        advance, fire, is_data, emit;
	logic [1:0]  e_status;
	logic [15:0] e_crc;
	logic [2:0]  e_nbytes;
	logic [15:0] crc_upd, crc_expect, rx_word;

	logic [1:0]  c_class;
	logic [7:0]  c_type;
	logic [3:0]  c_vc;
	logic [15:0] c_seq;
	logic [7:0]  c_hdr;
	logic [11:0] c_dat;

	// handshake: the symbol stage moves when the record slot is free or draining
	assign advance   = !rec_valid_q || !rec_stall;
	assign sym_stall = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;
	assign is_data   = (kind_s1 == KIND_DATA);

	// crc of the incoming byte and the expected received word
	assign crc_upd    = crc16_byte(crc_q, byte_s1);
	assign crc_expect = ~{crc_q[7:0], crc_q[15:8]};
	assign rx_word    = {crc_hi_q, byte_s1};

	// next state and record selection for one symbol
	always_comb begin
		nxt_phase  = phase_q;
		nxt_type   = type_q;
		nxt_body   = body_q;
		nxt_crc_hi = crc_hi_q;
		nxt_crc    = crc_q;
		nxt_good   = good_q;
		emit       = 1'b0;
		e_status   = STS_TRUNCATED;
		e_crc      = 16'd0;
		e_nbytes   = 3'd0;
		case (phase_q)
			PH_IDLE: begin
				if (kind_s1 == KIND_START) begin
					nxt_type   = 8'd0;
					nxt_body   = 24'd0;
					nxt_crc_hi = 8'd0;
					nxt_crc    = CRC_INIT;
					nxt_good   = 1'b0;
					nxt_phase  = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (!is_data) begin
					nxt_phase = PH_IDLE;
				end else begin
					nxt_type  = byte_s1;
					nxt_crc   = crc_upd;
					nxt_phase = PH_B1;
				end
			end
			PH_B1, PH_B2, PH_B3: begin
				if (!is_data) begin
					emit      = 1'b1;
					e_nbytes  = (phase_q == PH_B1) ? 3'd1 : (phase_q == PH_B2) ? 3'd2 : 3'd3;
					nxt_phase = PH_IDLE;
				end else begin
					nxt_body  = {body_q[15:0], byte_s1};
					nxt_crc   = crc_upd;
					nxt_phase = (phase_q == PH_B1) ? PH_B2 : (phase_q == PH_B2) ? PH_B3 : PH_C1;
				end
			end
			PH_C1: begin
				if (!is_data) begin
					emit      = 1'b1;
					e_nbytes  = 3'd4;
					nxt_phase = PH_IDLE;
				end else begin
					nxt_crc_hi = byte_s1;
					nxt_phase  = PH_C2;
				end
			end
			PH_C2: begin
				if (!is_data) begin
					emit      = 1'b1;
					e_crc     = {crc_hi_q, 8'd0};
					e_nbytes  = 3'd5;
					nxt_phase = PH_IDLE;
				end else begin
					nxt_good  = (rx_word == crc_expect);
					nxt_crc   = rx_word;
					nxt_phase = PH_END;
				end
			end
			default: begin
				emit      = 1'b1;
				e_crc     = crc_q;
				e_nbytes  = NBYTES_FULL;
				if (kind_s1 != KIND_END) begin
					e_status = STS_NO_END;
				end else begin
					e_status = good_q ? STS_OK : STS_CRC_BAD;
				end
				nxt_phase = PH_IDLE;
			end
		endcase
	end

	// classification and field extraction from the gathered bytes
	always_comb begin
		c_type = type_q;
		c_vc   = 4'd0;
		c_seq  = 16'd0;
		c_hdr  = 8'd0;
		c_dat  = 12'd0;
		case (type_q) inside
			TYPE_ACK, TYPE_NAK: begin
				c_class = CLS_ACKNAK;
				c_seq   = body_q[15:0];
			end
			TYPE_PM_L1, TYPE_PM_L23, TYPE_PM_AS_L1, TYPE_PM_REQ_ACK: begin
				c_class = CLS_PM;
			end
			TYPE_VENDOR: begin
				c_class = CLS_VENDOR;
			end
			default: begin
				c_class = CLS_FC;
				c_type  = {type_q[7:4], 4'd0};
				c_vc    = type_q[3:0];
				c_hdr   = {body_q[21:16], body_q[15:14]};
				c_dat   = {body_q[11:8], body_q[7:0]};
			end
		endcase
	end

	// symbol register, decoder state and record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			kind_s1     <= KIND_OTHER;
			byte_s1     <= 8'd0;
			phase_q     <= PH_IDLE;
			type_q      <= 8'd0;
			body_q      <= 24'd0;
			crc_hi_q    <= 8'd0;
			crc_q       <= CRC_INIT;
			good_q      <= 1'b0;
			rec_valid_q <= 1'b0;
			status_q    <= STS_OK;
			class_q     <= CLS_ACKNAK;
			type_out_q  <= 8'd0;
			vc_q        <= 4'd0;
			seq_q       <= 16'd0;
			hdr_q       <= 8'd0;
			dat_q       <= 12'd0;
			body_out_q  <= 24'd0;
			crc_rx_q    <= 16'd0;
			nbytes_q    <= 3'd0;
		end else begin
			if (!sym_stall) begin
				valid_s1 <= sym_valid;
				if (sym_valid) begin
					kind_s1 <= sym_kind;
					byte_s1 <= sym_byte;
				end
			end
			if (fire) begin
				phase_q  <= nxt_phase;
				type_q   <= nxt_type;
				body_q   <= nxt_body;
				crc_hi_q <= nxt_crc_hi;
				crc_q    <= nxt_crc;
				good_q   <= nxt_good;
			end
			if (advance) begin
				rec_valid_q <= fire && emit;
				if (fire && emit) begin
					status_q   <= e_status;
					class_q    <= c_class;
					type_out_q <= c_type;
					vc_q       <= c_vc;
					seq_q      <= c_seq;
					hdr_q      <= c_hdr;
					dat_q      <= c_dat;
					body_out_q <= body_q;
					crc_rx_q   <= e_crc;
					nbytes_q   <= e_nbytes;
				end
			end
		end
	end

	// record outputs
	assign rec_valid    = rec_valid_q;
	assign status       = status_q;
	assign dllp_class   = class_q;
	assign type_code    = type_out_q;
	assign vc_id        = vc_q;
	assign seq_field    = seq_q;
	assign hdr_credits  = hdr_q;
	assign data_credits = dat_q;
	assign body_payload = body_out_q;
	assign crc_received = crc_rx_q;
	assign bytes_seen   = nbytes_q;

endmodule

`default_nettype wire

FILE: rtl/pdllp_checker.sv
`default_nettype none

`include "pcie_dllp_decoder_core_defines.svh"

module pdllp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rec_valid,
	input  wire logic        rec_stall,
	input  wire logic [1:0]  status,
	input  wire logic [1:0]  dllp_class,
	input  wire logic [3:0]  vc_id,
	input  wire logic [15:0] seq_field,
	input  wire logic [2:0]  bytes_seen
);
	import pdllp_pkg::*;

	// a stalled record beat keeps its status
	`PDLLP_HOLD(a_status_hold, status, "record status changed while stalled")

	// a record that reached the end phase saw every dllp byte
	`PDLLP_ASSERT(a_full_len, (rec_valid && (status == STS_OK || status == STS_CRC_BAD || status == STS_NO_END)) |-> (bytes_seen == NBYTES_FULL), "completed record without six bytes")

	// a truncated record saw between one and five bytes
	`PDLLP_ASSERT(a_trunc_len, (rec_valid && status == STS_TRUNCATED) |-> (bytes_seen != 3'd0 && bytes_seen != NBYTES_FULL && bytes_seen != 3'd7), "truncated record with bad byte count")

	// only flow control carries a vc, only ack or nak a sequence
	`PDLLP_ASSERT(a_class_fields, (rec_valid && dllp_class != CLS_FC && dllp_class != CLS_ACKNAK) |-> (vc_id == 4'd0 && seq_field == 16'd0), "field set outside its dllp class")

endmodule

bind pcie_dllp_decoder_core pdllp_checker u_pdllp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rec_valid    (rec_valid),
	.rec_stall    (rec_stall),
	.status       (status),
	.dllp_class   (dllp_class),
	.vc_id        (vc_id),
	.seq_field    (seq_field),
	.bytes_seen   (bytes_seen)
);

`default_nettype wire
